// ===== design/bbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpe_pkg: shared types, constants and microprogram
// Constants, control word layout and the sequencer program store for the
// bicubic Bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbpe_pkg;

    localparam int AXES       = 3;
    localparam int ROW_STRIDE = 12;
    localparam int SLOTS      = 48;
    localparam int IDX_W      = 6;
    localparam int COORD_W    = 32;
    localparam int PARAM_W    = 17;
    localparam int SQ_W       = 33;
    localparam int WGT_W      = 49;
    localparam int WLO_W      = 24;
    localparam int ACC_W      = 60;
    localparam int SUM_W      = ACC_W - WLO_W;
    localparam int PC_W       = 5;
    localparam int CNT_W      = 4;

    localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [PC_W-1:0] PC_TERM1 = PC_W'(12);
    localparam logic [PC_W-1:0] PC_TERM2 = PC_W'(13);
    localparam logic [PC_W-1:0] PC_AXIS  = PC_W'(14);
    localparam logic [PC_W-1:0] PC_DONE  = PC_W'(17);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WMUL,
        OP_TERM1,
        OP_TERM2,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        WA_S,
        WA_A,
        WA_SQS,
        WA_SQA
    } wa_t;

    typedef enum logic {
        WB_S,
        WB_A
    } wb_t;

    typedef enum logic [2:0] {
        WD_SQS,
        WD_SQA,
        WD_W0,
        WD_W1,
        WD_W2,
        WD_W3
    } wdst_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_CNT,
        JC_AXIS
    } jc_t;

    typedef struct packed {
        op_t              op;
        wa_t              wa;
        wb_t              wb;
        wdst_t            wdst;
        logic             x3;
        logic             par;
        jc_t              jc;
        logic [PC_W-1:0]  target;
        logic [CNT_W-1:0] cnt_last;
    } uop_t;

    // One blend term on its way through read, multiply and accumulate.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic       pass2;
        logic [1:0] k;
        logic [1:0] dst;
    } term_t;

    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctrl_t;

    function automatic uop_t wstep(logic par, wa_t wa, wb_t wb, wdst_t dst, logic x3);
        uop_t u;
        u      = '0;
        u.op   = OP_WMUL;
        u.wa   = wa;
        u.wb   = wb;
        u.wdst = dst;
        u.x3   = x3;
        u.par  = par;
        return u;
    endfunction

    // Program: weights for u, weights for v, then per axis sixteen row terms,
    // four column terms and an axis step; a short drain precedes the result.
    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        u = '0;
        case (pc)
            PC_W'(0):  u = wstep(1'b0, WA_S,   WB_S, WD_SQS, 1'b0);
            PC_W'(1):  u = wstep(1'b0, WA_A,   WB_A, WD_SQA, 1'b0);
            PC_W'(2):  u = wstep(1'b0, WA_SQS, WB_S, WD_W0,  1'b0);
            PC_W'(3):  u = wstep(1'b0, WA_SQS, WB_A, WD_W1,  1'b1);
            PC_W'(4):  u = wstep(1'b0, WA_SQA, WB_S, WD_W2,  1'b1);
            PC_W'(5):  u = wstep(1'b0, WA_SQA, WB_A, WD_W3,  1'b0);
            PC_W'(6):  u = wstep(1'b1, WA_S,   WB_S, WD_SQS, 1'b0);
            PC_W'(7):  u = wstep(1'b1, WA_A,   WB_A, WD_SQA, 1'b0);
            PC_W'(8):  u = wstep(1'b1, WA_SQS, WB_S, WD_W0,  1'b0);
            PC_W'(9):  u = wstep(1'b1, WA_SQS, WB_A, WD_W1,  1'b1);
            PC_W'(10): u = wstep(1'b1, WA_SQA, WB_S, WD_W2,  1'b1);
            PC_W'(11): u = wstep(1'b1, WA_SQA, WB_A, WD_W3,  1'b0);
            PC_TERM1:
            begin
                u.op       = OP_TERM1;
                u.jc       = JC_CNT;
                u.target   = PC_TERM1;
                u.cnt_last = CNT_W'(15);
            end
            PC_TERM2:
            begin
                u.op       = OP_TERM2;
                u.jc       = JC_CNT;
                u.target   = PC_TERM2;
                u.cnt_last = CNT_W'(3);
            end
            PC_AXIS:
            begin
                u.jc     = JC_AXIS;
                u.target = PC_TERM1;
            end
            PC_DONE:   u.op = OP_DONE;
            default:   u = '0;
        endcase
        return u;
    endfunction

    function automatic logic [COORD_W-1:0] sat32(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(32'sh7FFF_FFFF);
        lo_lim = SUM_W'(32'sh8000_0000);
        if (v > hi_lim)
            return 32'h7FFF_FFFF;
        else if (v < lo_lim)
            return 32'h8000_0000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ===== design/bbpe_ram.sv =====
// ----------------------------------------------------------------------------
// bbpe_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbpe_ram #(
    parameter int Width = 32,
    parameter int Depth = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bbpe_mac.sv =====
// ----------------------------------------------------------------------------
// bbpe_mac: split-weight multiply-accumulate with rounding
// Multiplies a Q16.16 operand by the upper and lower parts of a 2^48-scaled
// weight, accumulates both sums and rounds the total to nearest.
// ----------------------------------------------------------------------------
module bbpe_mac
    import bbpe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [COORD_W-1:0] opnd,
    input  logic [WGT_W-1:0]          weight,
    output logic signed [SUM_W-1:0]   sum
);

    localparam int HI_W    = WGT_W - WLO_W;
    localparam int PHI_W   = COORD_W + HI_W + 1;
    localparam int PLO_W   = COORD_W + WLO_W + 1;

    logic signed [PHI_W-1:0] prod_hi_reg, prod_hi_next;
    logic signed [PLO_W-1:0] prod_lo_reg, prod_lo_next;
    logic signed [ACC_W-1:0] acc_hi_reg, acc_hi_next;
    logic signed [ACC_W-1:0] acc_lo_reg, acc_lo_next;
    logic signed [ACC_W-1:0] total;
    mac_ctrl_t               ctrl_reg;

    assign prod_hi_next = opnd * $signed({1'b0, weight[WGT_W-1:WLO_W]});
    assign prod_lo_next = opnd * $signed({1'b0, weight[WLO_W-1:0]});

    always_comb
    begin
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        if (ctrl_reg.valid)
        begin
            if (ctrl_reg.first)
            begin
                acc_hi_next = ACC_W'(prod_hi_reg);
                acc_lo_next = ACC_W'(prod_lo_reg);
            end
            else
            begin
                acc_hi_next = acc_hi_reg + ACC_W'(prod_hi_reg);
                acc_lo_next = acc_lo_reg + ACC_W'(prod_lo_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        acc_hi_reg  <= acc_hi_next;
        acc_lo_reg  <= acc_lo_next;
    end

    // The low sum is floored to the high scale first; together with the half
    // added here, the final floor gives round to nearest, ties upward.
    assign total = acc_hi_reg + (acc_lo_reg >>> WLO_W) + (ACC_W'(1) <<< (WLO_W - 1));
    assign sum   = total[ACC_W-1:WLO_W];

endmodule

// ===== design/bicubic_bezier_patch_eval.sv =====
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_eval: bicubic Bezier patch evaluator
// A write word stores one control point coordinate. An evaluate word presents
// x, y and z in the cycle in which the next word can first be accepted, after
// 12 weight steps on one weight multiplier, 60 blend terms through one split
// multiply-accumulate unit, one step per axis and a three-step drain. A result
// held off by m_tready stalls the last step.
// Reset clears the valid bits of the control point store, so unwritten
// coordinates read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_eval
    import bbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // point_index [5:0], point_value [37:6], param_u [54:38], param_v [71:55]
    input  logic [71:0] s_tdata,
    // command [0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic [95:0] m_tdata
);

    state_t state_reg, state_next;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;
    uop_t             uop;

    logic [PARAM_W-1:0] u_reg, v_reg;
    logic [SQ_W-1:0]    sq_s_reg, sq_a_reg;
    logic [WGT_W-1:0]   w_reg [8];

    logic [SLOTS-1:0]   valid_reg;
    logic               rd_valid_reg;
    term_t              d1_reg, d2_reg, d3_reg, issue;

    logic [COORD_W-1:0] row_res_reg [4];
    logic [COORD_W-1:0] res_reg [AXES];
    logic [95:0]        out_data_reg;
    logic               out_valid_reg;

    logic               in_fire, wr_fire, eval_fire, done_fire, out_free, running;
    logic [IDX_W-1:0]   in_index;
    logic [COORD_W-1:0] in_value;
    logic [IDX_W-1:0]   ram_raddr;
    logic [COORD_W-1:0] ram_rdata;

    logic [PARAM_W-1:0]      wt_a, wt_s;
    logic [SQ_W-1:0]         wa_val;
    logic [PARAM_W-1:0]      wb_val;
    logic [SQ_W+PARAM_W-1:0] wprod;
    logic [SQ_W+PARAM_W+1:0] wprod3;
    logic [WGT_W-1:0]        wres;

    logic signed [COORD_W-1:0] opnd;
    logic [WGT_W-1:0]          mac_w;
    logic signed [SUM_W-1:0]   mac_sum;
    mac_ctrl_t                 mac_ctrl;

    function automatic logic [PARAM_W-1:0] clamp_param(logic [PARAM_W-1:0] t);
        return (t > ONE_Q16) ? ONE_Q16 : t;
    endfunction

    assign in_index  = s_tdata[5:0];
    assign in_value  = s_tdata[37:6];
    assign in_fire   = s_tvalid && s_tready;
    assign wr_fire   = in_fire && (s_tuser[0] == CMD_WRITE);
    assign eval_fire = in_fire && (s_tuser[0] == CMD_EVAL);
    assign running   = (state_reg == ST_RUN);
    assign uop       = ucode(pc_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_fire)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (done_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        done_fire = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN:  done_fire = (uop.op == OP_DONE) && out_free;
            default: s_tready = 1'b0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        axis_next = axis_reg;
        if (eval_fire)
        begin
            pc_next   = '0;
            cnt_next  = '0;
            axis_next = '0;
        end
        else if (running && (uop.op != OP_DONE))
        begin
            case (uop.jc)
                JC_CNT:
                begin
                    if (cnt_reg != uop.cnt_last)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        pc_next  = uop.target;
                    end
                    else
                    begin
                        cnt_next = '0;
                        pc_next  = pc_reg + PC_W'(1);
                    end
                end
                JC_AXIS:
                begin
                    if (axis_reg != 2'(AXES - 1))
                    begin
                        axis_next = axis_reg + 2'd1;
                        pc_next   = uop.target;
                    end
                    else
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
                JC_NONE: pc_next = pc_reg + PC_W'(1);
                default: pc_next = pc_reg + PC_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    // ---------------- weight unit ----------------
    assign wt_a = uop.par ? v_reg : u_reg;
    assign wt_s = ONE_Q16 - wt_a;

    always_comb
    begin
        case (uop.wa)
            WA_S:    wa_val = SQ_W'(wt_s);
            WA_A:    wa_val = SQ_W'(wt_a);
            WA_SQS:  wa_val = sq_s_reg;
            WA_SQA:  wa_val = sq_a_reg;
            default: wa_val = '0;
        endcase
        case (uop.wb)
            WB_S:    wb_val = wt_s;
            WB_A:    wb_val = wt_a;
            default: wb_val = '0;
        endcase
    end

    assign wprod  = wa_val * wb_val;
    assign wprod3 = uop.x3 ? ((SQ_W+PARAM_W+2)'(wprod) + (SQ_W+PARAM_W+2)'({wprod, 1'b0}))
                           : (SQ_W+PARAM_W+2)'(wprod);
    assign wres   = wprod3[WGT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            u_reg <= clamp_param(s_tdata[54:38]);
            v_reg <= clamp_param(s_tdata[71:55]);
        end
        if (running && (uop.op == OP_WMUL))
        begin
            case (uop.wdst)
                WD_SQS:  sq_s_reg <= wprod[SQ_W-1:0];
                WD_SQA:  sq_a_reg <= wprod[SQ_W-1:0];
                WD_W0:   w_reg[{uop.par, 2'd0}] <= wres;
                WD_W1:   w_reg[{uop.par, 2'd1}] <= wres;
                WD_W2:   w_reg[{uop.par, 2'd2}] <= wres;
                WD_W3:   w_reg[{uop.par, 2'd3}] <= wres;
                default: sq_s_reg <= sq_s_reg;
            endcase
        end
    end

    // ---------------- control point store ----------------
    assign ram_raddr = IDX_W'(cnt_reg[3:2]) * IDX_W'(ROW_STRIDE)
                     + IDX_W'(cnt_reg[1:0]) * IDX_W'(AXES)
                     + IDX_W'(axis_reg);

    bbpe_ram #(
        .Width (COORD_W),
        .Depth (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_fire && (in_index < IDX_W'(SLOTS))),
        .waddr (in_index),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_fire && (in_index < IDX_W'(SLOTS)))
        begin
            valid_reg[in_index] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[ram_raddr];
    end

    // ---------------- term pipeline ----------------
    always_comb
    begin
        issue       = '0;
        issue.valid = running && ((uop.op == OP_TERM1) || (uop.op == OP_TERM2));
        issue.pass2 = (uop.op == OP_TERM2);
        issue.first = (cnt_reg[1:0] == 2'd0);
        issue.last  = (cnt_reg[1:0] == 2'd3);
        issue.k     = cnt_reg[1:0];
        issue.dst   = issue.pass2 ? axis_reg : cnt_reg[3:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
            d3_reg <= '0;
        end
        else
        begin
            d1_reg <= issue;
            d2_reg <= d1_reg;
            d3_reg <= d2_reg;
        end
    end

    assign opnd = d1_reg.pass2 ? $signed(row_res_reg[d1_reg.k])
                               : (rd_valid_reg ? $signed(ram_rdata) : '0);
    assign mac_w          = w_reg[{d1_reg.pass2, d1_reg.k}];
    assign mac_ctrl.valid = d1_reg.valid;
    assign mac_ctrl.first = d1_reg.first;

    bbpe_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .opnd   (opnd),
        .weight (mac_w),
        .sum    (mac_sum)
    );

    always_ff @(posedge clk)
    begin
        if (d3_reg.valid && d3_reg.last)
        begin
            if (d3_reg.pass2)
                res_reg[d3_reg.dst] <= sat32(mac_sum);
            else
                row_res_reg[d3_reg.dst] <= sat32(mac_sum);
        end
        if (done_fire)
        begin
            out_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    // ---------------- output word ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(d1_reg.valid || d2_reg.valid || d3_reg.valid))
        else $error("term still in flight while idle");

    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire |=> (state_reg == ST_IDLE) && m_tvalid)
        else $error("finished evaluation did not present a result");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (pc_reg <= PC_DONE))
        else $error("sequencer ran past the program");

    a_wmul_no_term: assert property (@(posedge clk) disable iff (!rst_n)
        (running && (uop.op == OP_WMUL)) |-> !d1_reg.valid)
        else $error("blend term overlaps weight generation");

endmodule
